FILE: sv/dsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distinct subsequence counter package
// Shared constants, command codes and the control word sent to every cell.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int SYMBOL_W = 8;
  localparam int RESULT_W = 32;
  localparam int SIZE_W   = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd3;

  typedef struct packed {
    logic                zero_counts;
    logic                append;
    logic                text;
    logic [SYMBOL_W-1:0] symbol;
  } dsc_ctl_t;

endpackage
`default_nettype wire

FILE: sv/dsc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix cell
// Holds one pattern byte and the saturating count of the prefix ending there.
// ----------------------------------------------------------------------------
module dsc_cell #(
  parameter int INDEX       = 0,
  parameter int COUNT_WIDTH = dsc_pkg::COUNT_WIDTH_DEF,
  parameter int LEN_W       = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsc_pkg::dsc_ctl_t      ctl,
  input  logic [LEN_W-1:0]       len,
  input  logic [COUNT_WIDTH-1:0] below,
  output logic [COUNT_WIDTH-1:0] count,
  output logic                   sat_hit
);
  import dsc_pkg::*;

  logic [SYMBOL_W-1:0]  pattern_byte;
  logic [COUNT_WIDTH:0] sum;
  logic                 active;
  logic                 at_tail;
  logic                 hit;
  logic                 sat;

  assign active  = len > LEN_W'(INDEX);
  assign at_tail = len == LEN_W'(INDEX);
  assign sum     = {1'b0, count} + {1'b0, below};
  assign sat     = sum[COUNT_WIDTH] | (&sum[COUNT_WIDTH-1:0]);
  assign hit     = ctl.text && active && (pattern_byte == ctl.symbol);
  assign sat_hit = hit && sat;

  always_ff @(posedge clk) begin
    if (ctl.append && at_tail) begin
      pattern_byte <= ctl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.zero_counts) begin
      count <= '0;
    end else if (ctl.append && at_tail) begin
      count <= '0;
    end else if (hit) begin
      count <= sat ? '1 : sum[COUNT_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: sv/distinct_subsequence_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distinct subsequence counter
// Counts the distinct occurrences of a loaded pattern as a subsequence of a
// streamed text, one prefix cell per pattern byte.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  item      item_valid / item_ready      command, symbol
//  result    result_valid / result_ready  subsequence_count, count_saturated,
//                                         pattern_dropped, pattern_size
//
// For every word, all cells update in parallel at the accepting
// edge, and the result is valid in the following cycle.
// A new word is taken in the same cycle in which the pending result is taken.
// While the result waits, item_ready stays low.
// Reset clears all counts, the pattern length and the flags.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter #(
  parameter int MAX_PATTERN = dsc_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH = dsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [dsc_pkg::CMD_W-1:0]     command,
  input  logic [dsc_pkg::SYMBOL_W-1:0]  symbol,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [dsc_pkg::RESULT_W-1:0]  subsequence_count,
  output logic                          count_saturated,
  output logic                          pattern_dropped,
  output logic [dsc_pkg::SIZE_W-1:0]    pattern_size
);
  import dsc_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0]       LEN_FULL  = LEN_W'(MAX_PATTERN);
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  logic                   accept;
  dsc_ctl_t               ctl;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       len_next;
  logic                   overflow;
  logic                   overflow_next;
  logic                   dropped;
  logic                   dropped_next;
  logic [COUNT_WIDTH-1:0] cell_count [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0] below_count [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0] tail_term [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_sat;
  logic [COUNT_WIDTH-1:0] tail_count;
  logic [COUNT_WIDTH-1:0] whole_count;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_comb begin
    ctl           = '0;
    ctl.symbol    = symbol;
    len_next      = len;
    overflow_next = overflow | (|cell_sat);
    dropped_next  = 1'b0;
    case (command)
      CMD_CLEAR: begin
        ctl.zero_counts = accept;
        len_next        = '0;
        overflow_next   = 1'b0;
      end
      CMD_APPEND: begin
        if (len < LEN_FULL) begin
          ctl.append = accept;
          len_next   = len + LEN_W'(1);
        end else begin
          dropped_next = 1'b1;
        end
      end
      CMD_RESTART: begin
        ctl.zero_counts = accept;
        overflow_next   = 1'b0;
      end
      CMD_TEXT: begin
        ctl.text = accept;
      end
      default: begin
      end
    endcase
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign below_count[j] = COUNT_ONE;
    end else begin : g_rest
      assign below_count[j] = cell_count[j-1];
    end

    dsc_cell #(
      .INDEX       (j),
      .COUNT_WIDTH (COUNT_WIDTH),
      .LEN_W       (LEN_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .len     (len),
      .below   (below_count[j]),
      .count   (cell_count[j]),
      .sat_hit (cell_sat[j])
    );

    assign tail_term[j] = (len == LEN_W'(j + 1)) ? cell_count[j] : '0;
  end

  always_comb begin
    tail_count = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      tail_count = tail_count | tail_term[j];
    end
  end

  assign whole_count = (len == '0) ? COUNT_ONE : tail_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      len          <= '0;
      overflow     <= 1'b0;
      dropped      <= 1'b0;
    end else begin
      if (accept) begin
        result_valid <= 1'b1;
        len          <= len_next;
        overflow     <= overflow_next;
        dropped      <= dropped_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  if (COUNT_WIDTH >= RESULT_W) begin : g_count_trunc
    assign subsequence_count = whole_count[RESULT_W-1:0];
  end else begin : g_count_ext
    assign subsequence_count = {{(RESULT_W - COUNT_WIDTH){1'b0}}, whole_count};
  end

  if (LEN_W >= SIZE_W) begin : g_size_trunc
    assign pattern_size = len[SIZE_W-1:0];
  end else begin : g_size_ext
    assign pattern_size = {{(SIZE_W - LEN_W){1'b0}}, len};
  end

  assign count_saturated = overflow;
  assign pattern_dropped = dropped;

endmodule
`default_nettype wire

FILE: sv/dsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distinct subsequence counter checker
// Port-level properties of the counter, bound to the top level.
// ----------------------------------------------------------------------------
module dsc_checker #(
  parameter int MAX_PATTERN = dsc_pkg::MAX_PATTERN_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [dsc_pkg::CMD_W-1:0]     command,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [dsc_pkg::RESULT_W-1:0]  subsequence_count,
  input logic                          count_saturated,
  input logic                          pattern_dropped,
  input logic [dsc_pkg::SIZE_W-1:0]    pattern_size
);
  import dsc_pkg::*;

  localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(MAX_PATTERN);
  localparam bit SIZE_EXACT = MAX_PATTERN < (1 << SIZE_W);

  logic item_accept;

  assign item_accept = item_valid && item_ready;

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(subsequence_count)
      && $stable(pattern_size))
    else $error("result word changed while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    item_accept && command == CMD_CLEAR |=> result_valid && pattern_size == '0
      && !count_saturated && !pattern_dropped && subsequence_count == RESULT_W'(1))
    else $error("clear did not empty the pattern");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    item_accept && command == CMD_RESTART |=> result_valid && !count_saturated
      && $stable(pattern_size) && !pattern_dropped)
    else $error("restart left counts or flags behind");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && pattern_dropped |-> pattern_size == FULL_SIZE)
    else $error("append dropped while pattern store not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    SIZE_EXACT && result_valid && pattern_size == '0 |-> subsequence_count == RESULT_W'(1))
    else $error("empty pattern must count one");

endmodule

bind distinct_subsequence_counter dsc_checker #(.MAX_PATTERN(MAX_PATTERN)) u_dsc_checker (.*);
`default_nettype wire
